/* rtl/core/bmslm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bmslm_pkg;

    // Width of the sample port and of the level result.
    localparam int SAMPLE_W = 24;
    localparam int LEVEL_W  = 15;

    // Register port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_LEVEL_MODE = 1'b0;

    typedef logic [1:0] t_level_mode;

    localparam t_level_mode MODE_INTEGRATED = 2'd0;
    localparam t_level_mode MODE_SHORT_TERM = 2'd1;
    localparam t_level_mode MODE_MOMENTARY  = 2'd2;
    localparam t_level_mode MODE_RMS        = 2'd3;

    // Fraction bits of the base-2 logarithm.
    localparam int LOG_FRAC = 20;

    // 1000*log10(2) in Q.24 is 5050445260. Its bits above 32 form exactly one,
    // so only the low word goes through the multiplier.
    localparam logic [31:0] CENTI_LOG2_LO = 32'd755477964;

    // 1e-6 in Q.31, added to the RMS value before the logarithm.
    localparam logic [31:0] EPS_Q31 = 32'd2147;

    // Upper bound of the scaled mean square.
    localparam logic [62:0] MEAN_CAP = 63'd1 << 62;

    // The RMS value is Q.31, so 31 comes off its logarithm.
    localparam logic signed [31:0] RMS_LOG_BASE = -(32'sd31 <<< LOG_FRAC);

    localparam logic signed [LEVEL_W-1:0] FLOOR_CENTI     = -15'sd12000;
    localparam logic signed [LEVEL_W-1:0] SILENT_CENTI    = -15'sd7000;
    localparam logic signed [LEVEL_W-1:0] SHORT_CENTI_OFS = 15'sd50;
    localparam logic signed [LEVEL_W-1:0] MOMENT_CENTI_OFS = 15'sd100;

    // Offsets of the Q.44 centi-dB value; ROUND_HALF is the half step that
    // makes the final shift round to nearest.
    localparam logic signed [63:0] ROUND_HALF    = 64'sd1 <<< 43;
    localparam logic signed [63:0] LOUD_OFS      = -((64'sd691 <<< 44) / 64'sd10);
    localparam logic signed [63:0] SHORT_OFS     = 64'sd50 <<< 44;
    localparam logic signed [63:0] MOMENT_OFS    = 64'sd100 <<< 44;

endpackage

`default_nettype wire

/* rtl/core/block_mean_square_level_meter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Block level meter. Each input request carries one signed sample (the low
// SAMPLE_BITS bits of i_sample_value, a two's complement fraction); when
// i_has_sample is set it is squared and added to a saturating 63-bit sum,
// and a sample count goes up, until the count reaches MAX_SAMPLES, after
// which further samples are dropped. A request with i_block_last set closes
// the block: one output request then carries the level in hundredths of a
// dB, rounded to nearest, and the sum and count are cleared. Modes 0 to 2
// report 10*log10(mean square) - 0.691 dB, plus 0.5 dB for short-term and
// 1.0 dB for momentary; mode 3 reports 20*log10(rms + 1e-6). An empty block
// reads -70 dB plus the mode offset, and a block of pure silence, or any
// level below -120 dB, reads -120 dB with o_floor_hit set. The mode register
// lies at APB address 0 and must only be written while the meter is idle.
// A request that carries no counted sample and does not close the block
// is consumed without leaving idle; a counted sample is accepted, squared
// on the shared 32x32 multiplier, then added with saturation. Closing a
// block runs a sequencer over one shared multiplier and bit-serial units.
// In the loudness modes two base-2 logarithms are taken (sum, then count),
// each a one-bit-per-cycle normalizing shift and 20 squaring rounds,
// followed by scaling and rounding. In RMS mode a restoring divider, a
// square root and one logarithm run in turn, then scaling and rounding.
// The meter takes no new input request while closing, but a finished level
// waits in its output register, so the next block can start before the
// level is taken.
module block_mean_square_level_meter_unit #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // APB register port
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [bmslm_pkg::ADDR_W-1:0]               paddr,
    input  logic [bmslm_pkg::DATA_W-1:0]               pwdata,
    output logic [bmslm_pkg::DATA_W-1:0]               prdata,
    output logic                                       pready,
    // Sample channel
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  logic signed [bmslm_pkg::SAMPLE_W-1:0]      i_sample_value,
    input  logic                                       i_has_sample,
    input  logic                                       i_block_last,
    // Level channel
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic signed [bmslm_pkg::LEVEL_W-1:0]       o_level_centi_db,
    output logic                                       o_floor_hit
);
    import bmslm_pkg::*;

    // The mean square is sum / (count * 2^QBITS). The RMS path divides
    // sum * 2^DIV_SHIFT by the count, giving a Q.62 mean square.
    localparam int QBITS     = 2 * (SAMPLE_BITS - 1);
    localparam int DIV_SHIFT = 62 - QBITS;
    localparam int NUM_W     = 63 + DIV_SHIFT;
    localparam int CNT_W     = $clog2(NUM_W);
    localparam int TALLY_W   = $clog2(MAX_SAMPLES + 1);
    localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(MAX_SAMPLES);
    localparam logic signed [31:0] LOUD_LOG_BASE = 32'(-(QBITS * (1 << LOG_FRAC)));

    // Sequencer states.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQR    = 4'd1;
    localparam logic [3:0] ST_ACC    = 4'd2;
    localparam logic [3:0] ST_CLOSE  = 4'd3;
    localparam logic [3:0] ST_DIV    = 4'd4;
    localparam logic [3:0] ST_SQINIT = 4'd5;
    localparam logic [3:0] ST_SQRT   = 4'd6;
    localparam logic [3:0] ST_SQEND  = 4'd7;
    localparam logic [3:0] ST_LNORM  = 4'd8;
    localparam logic [3:0] ST_LRND   = 4'd9;
    localparam logic [3:0] ST_LDONE  = 4'd10;
    localparam logic [3:0] ST_MUL    = 4'd11;
    localparam logic [3:0] ST_SUM    = 4'd12;
    localparam logic [3:0] ST_RND    = 4'd13;
    localparam logic [3:0] ST_DONE   = 4'd14;

    // Which operand the logarithm unit is working on.
    localparam logic [1:0] LSEL_SUM   = 2'd0;
    localparam logic [1:0] LSEL_TALLY = 2'd1;
    localparam logic [1:0] LSEL_RMS   = 2'd2;

    logic [3:0]                    r_state,      n_state;
    t_level_mode                   r_level_mode, n_level_mode;
    logic [62:0]                   r_sum,        n_sum;
    logic [TALLY_W-1:0]            r_tally,      n_tally;
    logic [SAMPLE_BITS-1:0]        r_mag,        n_mag;
    logic                          r_last,       n_last;
    logic [63:0]                   r_prod,       n_prod;
    logic [NUM_W-1:0]              r_num,        n_num;
    logic [TALLY_W-1:0]            r_rem,        n_rem;
    logic [62:0]                   r_q,          n_q;
    logic [63:0]                   r_root,       n_root;
    logic [63:0]                   r_bit,        n_bit;
    logic [CNT_W-1:0]              r_cnt,        n_cnt;
    logic [63:0]                   r_lv,         n_lv;
    logic [5:0]                    r_lp,         n_lp;
    logic [31:0]                   r_lm,         n_lm;
    logic [LOG_FRAC-1:0]           r_lf,         n_lf;
    logic [1:0]                    r_lsel,       n_lsel;
    logic signed [31:0]            r_acc,        n_acc;
    logic                          r_neg,        n_neg;
    logic signed [LEVEL_W-1:0]     r_centi,      n_centi;
    logic                          r_hit,        n_hit;
    logic                          r_out_valid,  n_out_valid;
    logic signed [LEVEL_W-1:0]     r_out_level,  n_out_level;
    logic                          r_out_hit,    n_out_hit;

    // Shared multiplier.
    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [63:0]            mul_p;

    logic [SAMPLE_BITS-1:0] sample_raw;
    logic [SAMPLE_BITS-1:0] sample_mag;
    logic                   take_sample;
    logic [63:0]            acc_sum;
    logic [TALLY_W:0]       div_trial;
    logic                   div_ge;
    logic [TALLY_W-1:0]     div_diff;
    logic [64:0]            sq_trial;
    logic                   sq_ge;
    logic [32:0]            lrnd_sq;
    logic signed [31:0]     log_val;
    logic [31:0]            abs_acc;
    logic signed [63:0]     rnd_ofs;
    logic signed [63:0]     rnd_t;
    logic signed [19:0]     rnd_c;
    logic                   apb_write;

    assign pready      = 1'b1;
    assign apb_write   = psel && penable && pwrite;
    assign prdata      = (paddr[ADDR_W-1] == REG_LEVEL_MODE) ? DATA_W'(r_level_mode) : '0;

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_level_centi_db = r_out_level;
    assign o_floor_hit      = r_out_hit;

    // Magnitude of the incoming sample; the most negative code maps to
    // 2^(SAMPLE_BITS-1), which still fits.
    assign sample_raw  = SAMPLE_BITS'($unsigned(i_sample_value));
    assign sample_mag  = sample_raw[SAMPLE_BITS-1] ? ('0 - sample_raw) : sample_raw;
    assign take_sample = i_has_sample && (r_tally < TALLY_MAX);

    assign acc_sum = {1'b0, r_sum} + r_prod;

    // Restoring division step.
    assign div_trial = {r_rem, r_num[NUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_tally});
    assign div_diff  = TALLY_W'(div_trial - {1'b0, r_tally});

    // Square root step.
    assign sq_trial = {1'b0, r_root} + {1'b0, r_bit};
    assign sq_ge    = ({2'b00, r_q} >= sq_trial);

    // Logarithm squaring round: mantissa squared, back to Q1.31.
    assign lrnd_sq = mul_p[63:31];
    assign log_val = $signed(32'({r_lp, r_lf}));

    assign abs_acc = r_acc[31] ? 32'(-r_acc) : 32'(r_acc);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_SQR: begin
                mul_a = 32'(r_mag);
                mul_b = 32'(r_mag);
            end
            ST_LRND: begin
                mul_a = r_lm;
                mul_b = r_lm;
            end
            ST_MUL: begin
                mul_a = abs_acc;
                mul_b = CENTI_LOG2_LO;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        case (r_level_mode)
            MODE_INTEGRATED: rnd_ofs = LOUD_OFS + ROUND_HALF;
            MODE_SHORT_TERM: rnd_ofs = LOUD_OFS + SHORT_OFS + ROUND_HALF;
            MODE_MOMENTARY:  rnd_ofs = LOUD_OFS + MOMENT_OFS + ROUND_HALF;
            default:         rnd_ofs = ROUND_HALF;
        endcase
    end

    assign rnd_t = r_neg ? (rnd_ofs - $signed(r_prod)) : (rnd_ofs + $signed(r_prod));
    assign rnd_c = rnd_t[63:44];

    always_comb begin
        n_state      = r_state;
        n_level_mode = r_level_mode;
        n_sum        = r_sum;
        n_tally      = r_tally;
        n_mag        = r_mag;
        n_last       = r_last;
        n_prod       = r_prod;
        n_num        = r_num;
        n_rem        = r_rem;
        n_q          = r_q;
        n_root       = r_root;
        n_bit        = r_bit;
        n_cnt        = r_cnt;
        n_lv         = r_lv;
        n_lp         = r_lp;
        n_lm         = r_lm;
        n_lf         = r_lf;
        n_lsel       = r_lsel;
        n_acc        = r_acc;
        n_neg        = r_neg;
        n_centi      = r_centi;
        n_hit        = r_hit;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_level  = r_out_level;
        n_out_hit    = r_out_hit;

        if (apb_write && (paddr[ADDR_W-1] == REG_LEVEL_MODE)) begin
            n_level_mode = pwdata[1:0];
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_mag  = sample_mag;
                    n_last = i_block_last;
                    if (take_sample) begin
                        n_state = ST_SQR;
                    end else if (i_block_last) begin
                        n_state = ST_CLOSE;
                    end
                end
            end
            ST_SQR: begin
                n_prod  = mul_p;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                // The sum saturates rather than wrapping.
                n_sum   = acc_sum[63] ? '1 : acc_sum[62:0];
                n_tally = r_tally + 1'b1;
                n_state = r_last ? ST_CLOSE : ST_IDLE;
            end
            ST_CLOSE: begin
                if (r_tally == '0) begin
                    // Empty block: the silent level still takes the mode offset.
                    n_hit = 1'b0;
                    case (r_level_mode)
                        MODE_SHORT_TERM: n_centi = SILENT_CENTI + SHORT_CENTI_OFS;
                        MODE_MOMENTARY:  n_centi = SILENT_CENTI + MOMENT_CENTI_OFS;
                        default:         n_centi = SILENT_CENTI;
                    endcase
                    n_state = ST_DONE;
                end else if (r_sum == '0) begin
                    n_centi = FLOOR_CENTI;
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else if (r_level_mode == MODE_RMS) begin
                    n_num   = NUM_W'(r_sum) << DIV_SHIFT;
                    n_rem   = '0;
                    n_q     = '0;
                    n_cnt   = CNT_W'(NUM_W - 1);
                    n_state = ST_DIV;
                end else begin
                    n_lv    = {1'b0, r_sum};
                    n_lp    = '1;
                    n_lsel  = LSEL_SUM;
                    n_acc   = LOUD_LOG_BASE;
                    n_state = ST_LNORM;
                end
            end
            ST_DIV: begin
                // The quotient never exceeds 2^62, so its top bits are dropped.
                n_rem = div_ge ? div_diff : div_trial[TALLY_W-1:0];
                n_q   = {r_q[61:0], div_ge};
                n_num = r_num << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_SQINIT;
                end
            end
            ST_SQINIT: begin
                n_q     = (r_q > MEAN_CAP) ? MEAN_CAP : r_q;
                n_root  = '0;
                n_bit   = 64'd1 << 62;
                n_cnt   = CNT_W'(31);
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (sq_ge) begin
                    n_q    = r_q - sq_trial[62:0];
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_SQEND;
                end
            end
            ST_SQEND: begin
                // The root is at most 2^31, so the offset sum stays in 32 bits.
                n_lv    = 64'(r_root[31:0] + EPS_Q31);
                n_lp    = '1;
                n_lsel  = LSEL_RMS;
                n_acc   = RMS_LOG_BASE;
                n_state = ST_LNORM;
            end
            ST_LNORM: begin
                if (r_lv[63]) begin
                    n_lm    = r_lv[63:32];
                    n_lf    = '0;
                    n_cnt   = CNT_W'(LOG_FRAC - 1);
                    n_state = ST_LRND;
                end else begin
                    n_lv = r_lv << 1;
                    n_lp = r_lp - 1'b1;
                end
            end
            ST_LRND: begin
                n_lm  = lrnd_sq[32] ? lrnd_sq[32:1] : lrnd_sq[31:0];
                n_lf  = {r_lf[LOG_FRAC-2:0], lrnd_sq[32]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_LDONE;
                end
            end
            ST_LDONE: begin
                case (r_lsel)
                    LSEL_SUM: begin
                        n_acc   = r_acc + log_val;
                        n_lv    = 64'(r_tally);
                        n_lp    = '1;
                        n_lsel  = LSEL_TALLY;
                        n_state = ST_LNORM;
                    end
                    LSEL_TALLY: begin
                        n_acc   = r_acc - log_val;
                        n_state = ST_MUL;
                    end
                    default: begin
                        // RMS scale is twice the loudness scale.
                        n_acc   = (r_acc + log_val) <<< 1;
                        n_state = ST_MUL;
                    end
                endcase
            end
            ST_MUL: begin
                n_prod  = mul_p;
                n_neg   = r_acc[31];
                n_state = ST_SUM;
            end
            ST_SUM: begin
                // The high word of the scale constant is one.
                n_prod  = r_prod + {abs_acc, 32'd0};
                n_state = ST_RND;
            end
            ST_RND: begin
                if (rnd_c < FLOOR_CENTI) begin
                    n_centi = FLOOR_CENTI;
                    n_hit   = 1'b1;
                end else begin
                    n_centi = rnd_c[LEVEL_W-1:0];
                    n_hit   = 1'b0;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_level = r_centi;
                    n_out_hit   = r_hit;
                    n_sum       = '0;
                    n_tally     = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_level_mode <= MODE_INTEGRATED;
            r_sum        <= '0;
            r_tally      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_level_mode <= n_level_mode;
            r_sum        <= n_sum;
            r_tally      <= n_tally;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag       <= n_mag;
        r_last      <= n_last;
        r_prod      <= n_prod;
        r_num       <= n_num;
        r_rem       <= n_rem;
        r_q         <= n_q;
        r_root      <= n_root;
        r_bit       <= n_bit;
        r_cnt       <= n_cnt;
        r_lv        <= n_lv;
        r_lp        <= n_lp;
        r_lm        <= n_lm;
        r_lf        <= n_lf;
        r_lsel      <= n_lsel;
        r_acc       <= n_acc;
        r_neg       <= n_neg;
        r_centi     <= n_centi;
        r_hit       <= n_hit;
        r_out_level <= n_out_level;
        r_out_hit   <= n_out_hit;
    end

    // A sample is only added while the count still has room.
    a_tally_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |-> (r_tally < TALLY_MAX))
        else $error("sample added to a full block");

    // Handing a level to the output register clears the block.
    a_clear_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && (!r_out_valid || i_out_ready)) |=>
        (o_out_valid && (r_sum == '0) && (r_tally == '0) && (r_state == ST_IDLE)))
        else $error("accumulators not cleared after a result");

    // The floor flag only goes with the floor level.
    a_floor_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_floor_hit) |-> (o_level_centi_db == FLOOR_CENTI))
        else $error("floor flag set away from the floor level");

endmodule

`default_nettype wire

/* sim/block_mean_square_level_meter_unit_tb.sv */
`timescale 1ns / 1ps

// Expected block levels, worked out from the accepted sample requests in order.
class level_scoreboard;

    localparam int QBITS = 2 * (bmslm_pkg::SAMPLE_W - 1);
    localparam int SAMPLE_CAP = 65536;
    localparam int LOG_FRAC = bmslm_pkg::LOG_FRAC;

    localparam longint CENTI_PER_LOG2 = 64'sd5050445260;
    localparam longint LOUDNESS_TRIM = -((64'sd691 <<< 44) / 64'sd10);
    localparam longint SHORT_TRIM = 64'sd50 <<< 44;
    localparam longint MOMENT_TRIM = 64'sd100 <<< 44;
    localparam longint HALF_STEP = 64'sd1 <<< 43;
    localparam longint unsigned SUM_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned MEAN_LIMIT = 64'd1 << 62;
    localparam longint unsigned RMS_EPSILON = 64'd2147;

    bmslm_pkg::t_level_mode mode;
    longint unsigned square_sum;
    int unsigned tally;

    logic [bmslm_pkg::LEVEL_W-1:0] level_q[$];
    logic floor_q[$];

    int errors;
    int requests;
    int results;
    int floor_hits;
    int empty_blocks;

    function new();
        mode = bmslm_pkg::MODE_INTEGRATED;
        square_sum = 0;
        tally = 0;
        errors = 0;
        requests = 0;
        results = 0;
        floor_hits = 0;
        empty_blocks = 0;
    endfunction

    function void set_mode(bmslm_pkg::t_level_mode m);
        mode = m;
    endfunction

    function int pending();
        return level_q.size();
    endfunction

    // Base-2 logarithm in Q.20: msb index, then one squaring round per
    // fraction bit on a Q1.31 mantissa.
    function longint log2_fix(longint unsigned v);
        int p;
        int i;
        longint unsigned m;
        longint frac;
        p = 63;
        while (p > 0 && v[p] == 1'b0) p--;
        if (p >= 31) m = v >> (p - 31);
        else m = v << (31 - p);
        frac = 0;
        for (i = LOG_FRAC - 1; i >= 0; i--) begin
            m = (m * m) >> 31;
            if ((m >> 32) != 0) begin
                frac = frac | (longint'(1) << i);
                m = m >> 1;
            end
        end
        return (longint'(p) << LOG_FRAC) | frac;
    endfunction

    function longint unsigned isqrt_floor(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function void predict_level(output logic [bmslm_pkg::LEVEL_W-1:0] level, output logic hit);
        longint c;
        longint x;
        longint unsigned q;
        longint unsigned rem;
        int k;
        hit = 1'b0;
        if (tally == 0) begin
            // An empty block still takes the mode offset.
            c = bmslm_pkg::SILENT_CENTI;
            if (mode == bmslm_pkg::MODE_SHORT_TERM) c += bmslm_pkg::SHORT_CENTI_OFS;
            else if (mode == bmslm_pkg::MODE_MOMENTARY) c += bmslm_pkg::MOMENT_CENTI_OFS;
            empty_blocks++;
        end else if (square_sum == 0) begin
            c = bmslm_pkg::FLOOR_CENTI;
            hit = 1'b1;
        end else begin
            if (mode == bmslm_pkg::MODE_RMS) begin
                // Scaled mean square by long division, then a Q.31 root.
                q = square_sum / tally;
                rem = square_sum % tally;
                for (k = 0; k < 62 - QBITS; k++) begin
                    if (q >= MEAN_LIMIT) begin
                        q = MEAN_LIMIT;
                        break;
                    end
                    rem = rem << 1;
                    q = q << 1;
                    if (rem >= tally) begin
                        rem = rem - tally;
                        q = q | 64'd1;
                    end
                end
                if (q > MEAN_LIMIT) q = MEAN_LIMIT;
                x = (log2_fix(isqrt_floor(q) + RMS_EPSILON) - (64'sd31 <<< LOG_FRAC))
                    * (2 * CENTI_PER_LOG2);
            end else begin
                x = (log2_fix(square_sum) - log2_fix(longint'(tally))
                     - (longint'(QBITS) <<< LOG_FRAC)) * CENTI_PER_LOG2 + LOUDNESS_TRIM;
                if (mode == bmslm_pkg::MODE_SHORT_TERM) x += SHORT_TRIM;
                else if (mode == bmslm_pkg::MODE_MOMENTARY) x += MOMENT_TRIM;
            end
            c = (x + HALF_STEP) >>> 44;
            if (c < bmslm_pkg::FLOOR_CENTI) begin
                c = bmslm_pkg::FLOOR_CENTI;
                hit = 1'b1;
            end
        end
        if (hit) floor_hits++;
        level = c[bmslm_pkg::LEVEL_W-1:0];
    endfunction

    function void note_request(logic signed [bmslm_pkg::SAMPLE_W-1:0] value, logic has,
                               logic last);
        longint s;
        longint unsigned sq;
        logic [bmslm_pkg::LEVEL_W-1:0] level;
        logic hit;
        requests++;
        // Once the block is full, further samples are dropped.
        if (has && tally < SAMPLE_CAP) begin
            s = value;
            if (s < 0) s = -s;
            sq = longint'(s) * longint'(s);
            if (sq > SUM_LIMIT - square_sum) square_sum = SUM_LIMIT;
            else square_sum = square_sum + sq;
            tally++;
        end
        if (last) begin
            predict_level(level, hit);
            level_q.push_back(level);
            floor_q.push_back(hit);
            square_sum = 0;
            tally = 0;
        end
    endfunction

    function void check_level(logic [bmslm_pkg::LEVEL_W-1:0] level, logic hit);
        logic [bmslm_pkg::LEVEL_W-1:0] want_level;
        logic want_hit;
        if (level_q.size() == 0) begin
            $error("level result %0d arrived with no block closed", $signed(level));
            errors++;
            return;
        end
        want_level = level_q.pop_front();
        want_hit = floor_q.pop_front();
        results++;
        if (level !== want_level) begin
            $error("level_centi_db: expected %0d, got %0d", $signed(want_level),
                   $signed(level));
            errors++;
        end
        if (hit !== want_hit) begin
            $error("floor_hit: expected %0b, got %0b", want_hit, hit);
            errors++;
        end
    endfunction

endclass

module block_mean_square_level_meter_unit_tb;

    import bmslm_pkg::*;

    localparam int METER_SAMPLE_BITS = 24;
    localparam int METER_MAX_SAMPLES = 65536;

    localparam int SETTLE_CYCLES = 256;
    localparam int HOLD_CYCLES = 1000;
    localparam int QUIET_LIMIT = 10000;

    localparam logic [ADDR_W-1:0] MODE_ADDR = ADDR_W'(4 * REG_LEVEL_MODE);
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(4 * (REG_LEVEL_MODE + 1));

    localparam logic signed [SAMPLE_W-1:0] NEG_FULL_SCALE = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] POS_FULL_SCALE = {1'b0, {(SAMPLE_W - 1){1'b1}}};

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample_value = '0;
    logic i_has_sample = 1'b0;
    logic i_block_last = 1'b0;

    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [LEVEL_W-1:0] o_level_centi_db;
    logic o_floor_hit;

    int gap_pct = 0;
    int stall_pct = 0;
    int offered = 0;
    int hold_orders = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    level_scoreboard sb;

    block_mean_square_level_meter_unit #(
        .SAMPLE_BITS(METER_SAMPLE_BITS),
        .MAX_SAMPLES(METER_MAX_SAMPLES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sample_value(i_sample_value),
        .i_has_sample(i_has_sample),
        .i_block_last(i_block_last),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_level_centi_db(o_level_centi_db),
        .o_floor_hit(o_floor_hit)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Level receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_taken != hold_orders) begin
            hold_taken <= hold_orders;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Both channels are sampled on the edge, before the block updates them.
    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_request(i_sample_value, i_has_sample, i_block_last);
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_level(o_level_centi_db, o_floor_hit);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $error("nothing moved on either channel for %0d cycles", QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes the mode with junk in the upper bits, pokes the unused index, and
    // reads the mode back.
    task automatic set_mode(input t_level_mode mode);
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] readback;
        word = $urandom;
        word[1:0] = mode;
        apb_write(MODE_ADDR, word);
        sb.set_mode(mode);
        apb_write(UNMAPPED_ADDR, $urandom);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= MODE_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback[1:0] !== mode) begin
            $error("level_mode readback: expected %0d, got %0d", mode, readback[1:0]);
            sb.errors++;
        end
    endtask

    task automatic send_request(input logic signed [SAMPLE_W-1:0] value, input logic has,
                                input logic last);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_value <= value;
        i_has_sample <= has;
        i_block_last <= last;
        offered++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // One block: a mostly short run of samples in one amplitude style, with
    // ignored requests mixed in, closed on a sample or by an empty request.
    task automatic send_random_block();
        int pick;
        int len;
        int style;
        int k;
        bit close_on_sample;
        logic signed [SAMPLE_W-1:0] value;
        pick = $urandom_range(99);
        if (pick < 6) len = 0;
        else if (pick < 80) len = $urandom_range(12, 1);
        else if (pick < 96) len = $urandom_range(60, 13);
        else len = $urandom_range(300, 61);
        style = $urandom_range(4);
        close_on_sample = (len != 0) && ($urandom_range(1) == 1);
        for (k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0) send_request(SAMPLE_W'($urandom), 1'b0, 1'b0);
            case (style)
                0: value = SAMPLE_W'($urandom);
                1: value = SAMPLE_W'(int'($urandom_range(48)) - 24);
                2: value = '0;
                3: value = ($urandom_range(1) == 1) ? NEG_FULL_SCALE : POS_FULL_SCALE;
                default: begin
                    value = SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1);
                    if ($urandom_range(1) == 1) value = -value;
                end
            endcase
            send_request(value, 1'b1, close_on_sample && (k == len - 1));
        end
        if (!close_on_sample) send_request(SAMPLE_W'($urandom), 1'b0, 1'b1);
    endtask

    task automatic run_random_phase(input int quota);
        int start;
        start = offered;
        while (offered - start < quota) send_random_block();
    endtask

    // Stop sending, let every level come back, then give a block that may
    // still be busy with a last sample time to go idle.
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_level_mode sweep[3];
        int n;
        sweep[0] = MODE_SHORT_TERM;
        sweep[1] = MODE_MOMENTARY;
        sweep[2] = MODE_RMS;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_mode(MODE_INTEGRATED);

        // Directed blocks: empty, silent, full scale, below the floor, and
        // requests whose sample must not count.
        send_request(POS_FULL_SCALE, 1'b0, 1'b1);
        send_request('0, 1'b1, 1'b0);
        send_request('0, 1'b1, 1'b1);
        send_request(NEG_FULL_SCALE, 1'b1, 1'b0);
        send_request(POS_FULL_SCALE, 1'b1, 1'b1);
        send_request(SAMPLE_W'(1), 1'b1, 1'b1);
        send_request(POS_FULL_SCALE, 1'b0, 1'b0);
        send_request(-SAMPLE_W'(1), 1'b1, 1'b0);
        send_request(NEG_FULL_SCALE, 1'b0, 1'b1);
        send_request(SAMPLE_W'(4096), 1'b1, 1'b1);
        foreach (sweep[j]) begin
            finish_phase();
            set_mode(sweep[j]);
            send_request(-SAMPLE_W'(1), 1'b0, 1'b1);
            send_request('0, 1'b1, 1'b1);
            send_request(NEG_FULL_SCALE, 1'b1, 1'b1);
            send_request(SAMPLE_W'(3), 1'b1, 1'b1);
        end

        // Random traffic. The first phase holds the receiver off while short
        // blocks keep coming, so the output register fills and input stalls.
        finish_phase();
        set_mode(MODE_INTEGRATED);
        gap_pct = 0;
        stall_pct = 0;
        hold_orders <= hold_orders + 1;
        for (n = 0; n < 12; n++) send_request(SAMPLE_W'($urandom), 1'b1, 1'b1);
        run_random_phase(250);

        finish_phase();
        set_mode(MODE_RMS);
        gap_pct = 51;
        stall_pct = 0;
        run_random_phase(260);

        finish_phase();
        set_mode(MODE_SHORT_TERM);
        gap_pct = 0;
        stall_pct = 51;
        run_random_phase(260);

        finish_phase();
        set_mode(MODE_MOMENTARY);
        gap_pct = 31;
        stall_pct = 31;
        run_random_phase(260);

        finish_phase();
        $display("Covered %0d requests and %0d block levels in all four modes,",
                 sb.requests, sb.results);
        $display("including %0d floor hits and %0d empty blocks.",
                 sb.floor_hits, sb.empty_blocks);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/bmslm_pkg.sv
rtl/core/block_mean_square_level_meter_unit.sv
sim/block_mean_square_level_meter_unit_tb.sv
